/* rtl/core/slgnh_pkg.sv */
// shared types, widths and helpers for the straight-line greedy next-hop block
// no dependencies; every other file of the block imports this package
package slgnh_pkg;

    // coordinate and address widths
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 16;

    // derived arithmetic widths: difference, product, sum of products
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    // request type codes
    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_NBR   = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [ADDR_BITS-1:0]  t_addr;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod_val;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef logic        [SUM_BITS-1:0]   t_mag;

    // one input transfer
    typedef struct packed {
        logic   req_type;
        t_coord self_x;
        t_coord self_y;
        t_coord src_x;
        t_coord src_y;
        t_coord dst_x;
        t_coord dst_y;
        t_addr  dest_addr;
        t_addr  nbr_addr;
        t_coord nbr_x;
        t_coord nbr_y;
        logic   last;
    } t_req;

    // one result transfer
    typedef struct packed {
        t_addr next_hop_addr;
        logic  found;
        logic  is_destination;
    } t_rsp;

    // product stage contents handed to the select stage
    typedef struct packed {
        logic      is_begin;
        logic      last;
        logic      hit;
        logic      line_pt;
        t_addr     addr;
        t_prod_val sq0;
        t_prod_val sq1;
        t_prod_val cr0;
        t_prod_val cr1;
    } t_prod;

    // sign-extended difference a - b
    function automatic t_diff sdiff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

endpackage

/* rtl/core/slgnh_prod.sv */
// product stage: latches the query positions and forms squares and cross terms
// depends on slgnh_pkg
module slgnh_prod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  slgnh_pkg::t_req    i_req,
    output slgnh_pkg::t_prod   o_prod
);
    import slgnh_pkg::*;

    t_coord r_src_x, r_src_y, r_dst_x, r_dst_y;
    t_diff  r_cx, r_cy;
    t_addr  r_target;
    logic   r_line_pt;
    t_prod  r_prod;

    logic   is_begin;
    t_diff  sq_a, sq_b, cr_a, cr_b;
    t_prod  n_prod;

    assign is_begin = (i_req.req_type == REQ_BEGIN);

    // operand select ahead of the four multipliers
    always_comb begin
        if (is_begin) begin
            sq_a = sdiff(i_req.self_x, i_req.dst_x);
            sq_b = sdiff(i_req.self_y, i_req.dst_y);
        end else begin
            sq_a = sdiff(i_req.nbr_x, r_dst_x);
            sq_b = sdiff(i_req.nbr_y, r_dst_y);
        end
        cr_a = sdiff(i_req.nbr_y, r_src_y);
        cr_b = sdiff(i_req.nbr_x, r_src_x);
    end

    // products and per-item flags
    always_comb begin
        n_prod.is_begin = is_begin;
        n_prod.last     = i_req.last;
        n_prod.hit      = (i_req.nbr_addr == r_target);
        n_prod.line_pt  = r_line_pt;
        n_prod.addr     = i_req.nbr_addr;
        n_prod.sq0      = sq_a * sq_a;
        n_prod.sq1      = sq_b * sq_b;
        n_prod.cr0      = r_cx * cr_a;
        n_prod.cr1      = r_cy * cr_b;
    end

    // query positions, latched by a begin transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x   <= '0;
            r_src_y   <= '0;
            r_dst_x   <= '0;
            r_dst_y   <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_target  <= '0;
            r_line_pt <= 1'b0;
        end else if (i_en && is_begin) begin
            r_src_x   <= i_req.src_x;
            r_src_y   <= i_req.src_y;
            r_dst_x   <= i_req.dst_x;
            r_dst_y   <= i_req.dst_y;
            r_cx      <= sdiff(i_req.dst_x, i_req.src_x);
            r_cy      <= sdiff(i_req.dst_y, i_req.src_y);
            r_target  <= i_req.dest_addr;
            r_line_pt <= (i_req.src_x == i_req.dst_x) && (i_req.src_y == i_req.dst_y);
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/slgnh_select.sv */
// select stage: distance test, cross-product compare and running best, result register
// depends on slgnh_pkg
module slgnh_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  slgnh_pkg::t_prod   i_prod,
    output slgnh_pkg::t_rsp    o_rsp
);
    import slgnh_pkg::*;

    t_sum  r_self_dsq;
    t_mag  r_best_cr;
    t_addr r_best_addr;
    logic  r_have_best;
    logic  r_dest_hit;
    t_rsp  r_rsp;

    t_sum  dsq;
    t_sum  cr;
    t_mag  cr_abs;
    logic  closer;
    t_sum  n_self_dsq;
    t_mag  n_best_cr;
    t_addr n_best_addr;
    logic  n_have_best;
    logic  n_dest_hit;
    logic  n_found;
    t_rsp  n_rsp;

    // sums of products
    always_comb begin
        dsq    = t_sum'(i_prod.sq0) + t_sum'(i_prod.sq1);
        cr     = t_sum'(i_prod.cr0) - t_sum'(i_prod.cr1);
        cr_abs = (cr < 0) ? t_mag'(-cr) : t_mag'(cr);
        closer = (dsq < r_self_dsq);
    end

    // running selection update
    always_comb begin
        n_self_dsq  = r_self_dsq;
        n_best_cr   = r_best_cr;
        n_best_addr = r_best_addr;
        n_have_best = r_have_best;
        n_dest_hit  = r_dest_hit;
        if (i_prod.is_begin) begin
            n_self_dsq  = dsq;
            n_best_cr   = '0;
            n_best_addr = '0;
            n_have_best = 1'b0;
            n_dest_hit  = 1'b0;
        end else if (!r_dest_hit) begin
            if (i_prod.hit) begin
                n_dest_hit  = 1'b1;
                n_best_addr = i_prod.addr;
            end else if (!i_prod.line_pt && closer) begin
                if (!r_have_best || (cr_abs < r_best_cr)) begin
                    n_best_cr   = cr_abs;
                    n_best_addr = i_prod.addr;
                    n_have_best = 1'b1;
                end
            end
        end
        n_found              = n_dest_hit || n_have_best;
        n_rsp.next_hop_addr  = n_found ? n_best_addr : '0;
        n_rsp.found          = n_found;
        n_rsp.is_destination = n_dest_hit;
        // a result closes the query and clears the selection
        if (i_prod.last) begin
            n_best_cr   = '0;
            n_best_addr = '0;
            n_have_best = 1'b0;
            n_dest_hit  = 1'b0;
        end
    end

    // selection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_dsq  <= '0;
            r_best_cr   <= '0;
            r_best_addr <= '0;
            r_have_best <= 1'b0;
            r_dest_hit  <= 1'b0;
        end else if (i_en) begin
            r_self_dsq  <= n_self_dsq;
            r_best_cr   <= n_best_cr;
            r_best_addr <= n_best_addr;
            r_have_best <= n_have_best;
            r_dest_hit  <= n_dest_hit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_en && i_prod.last) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* rtl/core/straight_line_greedy_next_hop.sv */
// top level of the straight-line greedy next-hop selector: input register and flow control
// depends on slgnh_pkg, slgnh_prod and slgnh_select
//
// A begin transfer sets up a query; neighbor transfers then stream in and the
// transfer with last set gives one result: the destination if it was seen,
// else the closer-than-self neighbor nearest the source-destination line.
// The block takes one transfer per clock cycle, sustained, and holds back only
// while a result waits at the output, the product register holds the next item
// with last set and the input register is occupied. The transfer that carries
// last reaches the output through the input register, the product register and
// the result register. Items without last flow on while a result waits to be
// taken.
module straight_line_greedy_next_hop (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  slgnh_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output slgnh_pkg::t_rsp  o_rsp
);
    import slgnh_pkg::*;

    t_req  r_in;
    logic  r_in_valid;
    logic  r_p_valid;
    logic  r_out_valid;

    t_prod prod;
    logic  out_rdy;
    logic  p_adv;
    logic  p_free;
    logic  in_adv;
    logic  in_free;
    logic  in_xfer;

    // stage advance conditions, from the output back
    always_comb begin
        out_rdy = !r_out_valid || !i_stall;
        p_adv   = r_p_valid && (!prod.last || out_rdy);
        p_free  = !r_p_valid || p_adv;
        in_adv  = r_in_valid && p_free;
        in_free = !r_in_valid || p_free;
        in_xfer = i_valid && in_free;
    end

    assign o_stall = !in_free;
    assign o_valid = r_out_valid;

    // input register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_req;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (p_free) begin
                r_p_valid <= r_in_valid;
            end
            if (p_adv && prod.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    slgnh_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_adv),
        .i_req   (r_in),
        .o_prod  (prod)
    );

    slgnh_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (p_adv),
        .i_prod  (prod),
        .o_rsp   (o_rsp)
    );

    // a destination result is always a found result
    a_dest_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.found || !o_rsp.is_destination))
        else $error("destination result without found");

    // a fallback result carries a zero address
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.found) |-> (o_rsp.next_hop_addr == '0))
        else $error("fallback result with nonzero address");

    // with the result register empty the input side never holds back
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled with empty result register");

    // a result appears only after a last item left the product stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_p_valid && prod.last))
        else $error("result without a last item");

endmodule
